/* rtl/pcta_pkg.sv */
// Shared types and constants for the pair count table with argmax search.
`default_nettype none
package pcta_pkg;

	localparam int VOCAB_SIZE_DEF  = 256;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TOKEN_W         = 8;
	localparam int AMOUNT_W        = 32;
	localparam int OUT_COUNT_W     = 32;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_FIND  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [TOKEN_W-1:0]  first_token;
		logic [TOKEN_W-1:0]  second_token;
		logic [AMOUNT_W-1:0] amount;
	} item_t;

	typedef struct packed {
		logic [TOKEN_W-1:0]     pair_first;
		logic [TOKEN_W-1:0]     pair_second;
		logic [OUT_COUNT_W-1:0] count;
	} result_t;

	// Requests from the front stage to the table sweeper.
	typedef struct packed {
		logic start;
		logic find;
		logic ack;
	} scan_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} scan_stat_t;

endpackage
`default_nettype wire

/* rtl/pair_count_table_argmax.sv */
// Top level: pair count table with saturating add, argmax search and clear.
// Add: result registered; one add per cycle unless stalled, with write forwarding.
// Find: one memory read per cycle over the whole table.
// Clear: one memory write per cycle.
// Reset: a clearing pass over the whole table, no items taken.
`default_nettype none
module pair_count_table_argmax
	import pcta_pkg::*;
#(
	parameter int VOCAB_SIZE  = VOCAB_SIZE_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	localparam int IDX_W  = $clog2(VOCAB_SIZE);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int SUM_W  = ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// front stage
	logic                   valid_s1;
	mode_t                  mode_s1;
	logic [TOKEN_W-1:0]     first_s1;
	logic [TOKEN_W-1:0]     second_s1;
	logic [AMOUNT_W-1:0]    amt_s1;
	logic                   inrange_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic                   hit_s1;
	logic [COUNT_WIDTH-1:0] hitdata_s1;

	logic                   result_valid_q;
	result_t                result_q;

	logic                   accept;
	logic                   slot_free;
	logic                   s1_adv;
	logic                   add_wr;
	logic                   fin;
	logic                   in_inrange;
	logic [ADDR_W-1:0]      in_addr;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [SUM_W-1:0]       sum;
	logic [COUNT_WIDTH-1:0] new_cnt;

	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	scan_cmd_t              scan_cmd;
	scan_stat_t             scan_stat;
	logic [ADDR_W-1:0]      scan_addr;
	logic                   scan_we;
	logic                   scan_re;
	logic [ADDR_W-1:0]      best_addr;
	logic [COUNT_WIDTH-1:0] best_count;

	assign slot_free  = !result_valid_q || result_ready;
	assign s1_adv     = valid_s1 && scan_stat.idle && slot_free
	                    && (mode_s1 == MODE_ADD || mode_s1 == MODE_NONE);
	assign item_ready = scan_stat.idle && (!valid_s1 || s1_adv);
	assign accept     = item_valid && item_ready;
	assign add_wr     = s1_adv && mode_s1 == MODE_ADD && inrange_s1;
	assign fin        = scan_stat.done && slot_free;

	assign in_inrange = ({24'd0, item.first_token} < 32'(VOCAB_SIZE))
	                    && ({24'd0, item.second_token} < 32'(VOCAB_SIZE));
	assign in_addr    = {IDX_W'(item.first_token), IDX_W'(item.second_token)};

	// Saturating add; take the word written as this item was accepted if it hit this entry.
	assign cur_cnt = hit_s1 ? hitdata_s1 : ram_rdata;
	assign sum     = SUM_W'(cur_cnt) + SUM_W'(amt_s1);
	assign new_cnt = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(sum);

	assign scan_cmd.start = valid_s1 && scan_stat.idle
	                        && (mode_s1 == MODE_FIND || mode_s1 == MODE_CLEAR);
	assign scan_cmd.find  = (mode_s1 == MODE_FIND);
	assign scan_cmd.ack   = fin;

	assign ram_re    = scan_re || accept;
	assign ram_raddr = scan_re ? scan_addr : in_addr;
	assign ram_we    = scan_we || add_wr;
	assign ram_waddr = scan_we ? scan_addr : addr_s1;
	assign ram_wdata = scan_we ? '0 : new_cnt;

	pcta_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (COUNT_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pcta_scan #(
		.ADDR_W      (ADDR_W),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (scan_cmd),
		.rd_data    (ram_rdata),
		.mem_addr   (scan_addr),
		.mem_we     (scan_we),
		.mem_re     (scan_re),
		.stat       (scan_stat),
		.best_addr  (best_addr),
		.best_count (best_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv || fin) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= item.mode;
			first_s1   <= item.first_token;
			second_s1  <= item.second_token;
			amt_s1     <= item.amount;
			inrange_s1 <= in_inrange;
			addr_s1    <= in_addr;
			// the read issued now misses the write landing at this edge
			hit_s1     <= add_wr && (addr_s1 == in_addr);
			hitdata_s1 <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_adv || fin) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (mode_s1 == MODE_ADD) begin
				result_q.pair_first  <= first_s1;
				result_q.pair_second <= second_s1;
				result_q.count       <= inrange_s1 ? OUT_COUNT_W'(new_cnt) : '0;
			end else begin
				result_q <= '0;
			end
		end else if (fin) begin
			if (mode_s1 == MODE_FIND) begin
				result_q.pair_first  <= TOKEN_W'(best_addr[ADDR_W-1:IDX_W]);
				result_q.pair_second <= TOKEN_W'(best_addr[IDX_W-1:0]);
				result_q.count       <= OUT_COUNT_W'(best_count);
			end else begin
				result_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

/* rtl/pcta_ram.sv */
// Simple dual-port count memory: one write port, one registered read port.
`default_nettype none
module pcta_ram
	import pcta_pkg::*;
#(
	parameter int ADDR_W = 16,
	parameter int DATA_W = COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read returns the old word on a same-address write.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/pcta_scan.sv */
// Table sweeper: clearing pass and row-major argmax search over the memory.
`default_nettype none
module pcta_scan
	import pcta_pkg::*;
#(
	parameter int ADDR_W      = 16,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire scan_cmd_t              cmd,
	input  wire logic [COUNT_WIDTH-1:0] rd_data,
	output logic      [ADDR_W-1:0]      mem_addr,
	output logic                        mem_we,
	output logic                        mem_re,
	output scan_stat_t                  stat,
	output logic      [ADDR_W-1:0]      best_addr,
	output logic      [COUNT_WIDTH-1:0] best_count
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CLEAR = 5'b00010,
		S_FIND  = 5'b00100,
		S_TAIL  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] scan_q;
	logic              report_q;
	logic              cmp_vld_q;
	logic [ADDR_W-1:0] cmp_addr_q;
	logic [ADDR_W-1:0] best_addr_q;
	logic [COUNT_WIDTH-1:0] best_q;
	logic              last;

	assign last     = (scan_q == '1);
	assign mem_addr = scan_q;
	assign mem_we   = (state_q == S_CLEAR);
	assign mem_re   = (state_q == S_FIND);

	assign stat.idle  = (state_q == S_IDLE);
	assign stat.done  = (state_q == S_DONE);
	assign best_addr  = best_addr_q;
	assign best_count = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			scan_q    <= '0;
			report_q  <= 1'b0;
			cmp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cmp_vld_q <= 1'b0;
					scan_q    <= '0;
					if (cmd.start) begin
						report_q <= 1'b1;
						state_q  <= cmd.find ? S_FIND : S_CLEAR;
					end
				end
				S_CLEAR: begin
					scan_q <= scan_q + 1'b1;
					if (last) begin
						state_q <= report_q ? S_DONE : S_IDLE;
					end
				end
				S_FIND: begin
					scan_q    <= scan_q + 1'b1;
					cmp_vld_q <= 1'b1;
					if (last) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					cmp_vld_q <= 1'b0;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (cmd.ack) begin
						report_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Compare each returned word; strict greater keeps the first maximum.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.start) begin
			best_q      <= '0;
			best_addr_q <= '0;
		end else if (cmp_vld_q && rd_data > best_q) begin
			best_q      <= rd_data;
			best_addr_q <= cmp_addr_q;
		end
		cmp_addr_q <= scan_q;
	end

endmodule
`default_nettype wire

/* rtl/pcta_chk.sv */
// Port-level checker for the pair count table, bound to the top level.
`default_nettype none
module pcta_chk
	import pcta_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed or dropped while stalled");

	// a find or clear sweep blocks the next word
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.mode == MODE_FIND || item.mode == MODE_CLEAR)
		|=> !item_ready)
		else $error("input taken right after a find or clear");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	// the clearing pass after reset holds off input
	a_init_clear: assert property (@(posedge clk)
		$rose(arst_n) |-> !item_ready)
		else $error("input ready before the reset clearing pass");

endmodule

bind pair_count_table_argmax pcta_chk u_pcta_chk (.*);
`default_nettype wire
